FILE: hdl/ebq_pkg.sv
// Types, codes and the quadrature transition table shared by the encoder and button qualifier.
package ebq_pkg;

   localparam int NUM_BUTTONS = 5;
   localparam int CSR_ADDR_BITS = 8;
   localparam int CSR_DATA_BITS = 16;

   // button positions within button_levels
   localparam int BTN_KNOB    = 0;
   localparam int BTN_VOLT    = 1;
   localparam int BTN_TIME    = 2;
   localparam int BTN_TRIGGER = 3;
   localparam int BTN_OK      = 4;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEBOUNCE   = 8'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LONG_PRESS = 8'd1;

   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CSR_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

   // quadrature phase codes, A is the high bit
   localparam logic [1:0] PH_00 = 2'b00;
   localparam logic [1:0] PH_01 = 2'b01;
   localparam logic [1:0] PH_10 = 2'b10;
   localparam logic [1:0] PH_11 = 2'b11;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_SHORT = 2'd1,
      EVT_LONG  = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      MOVE_NONE = 2'd0,
      MOVE_UP   = 2'd1,
      MOVE_DOWN = 2'd2
   } move_type;

   typedef struct packed {
      logic       phase_a;
      logic       phase_b;
      logic [4:0] button_levels;
      logic       ms_tick;
   } req_type;

   typedef struct packed {
      logic signed [1:0] detent_steps;
      event_type         knob_event;
      event_type         volt_event;
      event_type         time_event;
      event_type         trigger_event;
      event_type         ok_event;
   } rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_BITS-1:0] addr;
      logic [CSR_DATA_BITS-1:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] debounce_ms;
      logic [CSR_DATA_BITS-1:0] long_press_ms;
   } cfg_type;

   function automatic move_type phase_move(input logic [1:0] prev, input logic [1:0] now);
      move_type m;
      case ({prev, now})
         {PH_01, PH_11}, {PH_11, PH_10}, {PH_10, PH_00}, {PH_00, PH_01}: m = MOVE_UP;
         {PH_00, PH_10}, {PH_10, PH_11}, {PH_11, PH_01}, {PH_01, PH_00}: m = MOVE_DOWN;
         default: m = MOVE_NONE;
      endcase
      return m;
   endfunction

endpackage

FILE: hdl/ebq_chan_if.sv
// Valid/ready channel carrying one payload struct per beat.
interface ebq_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ebq_quad.sv
// Quadrature phase tracker and detent step extraction with carried remainder.
module ebq_quad (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [1:0]        phase,
   output logic signed [1:0] detent_steps
);
   import ebq_pkg::*;

   logic [1:0]        last_phase_ff;
   logic signed [1:0] residual_ff;   // count not yet reported, -1..1
   logic signed [1:0] residual_in;
   logic signed [2:0] delta;
   move_type          move;

   always_comb begin
      move = phase_move(last_phase_ff, phase);
      case (move)
         MOVE_UP:   delta = 3'(residual_ff) + 3'sd1;
         MOVE_DOWN: delta = 3'(residual_ff) - 3'sd1;
         default:   delta = 3'(residual_ff);
      endcase
      // two counts make one detent; anything less stays as residual
      if (delta == 3'sd2) begin
         detent_steps = 2'sd1;
         residual_in  = 2'sd0;
      end else if (delta == -3'sd2) begin
         detent_steps = -2'sd1;
         residual_in  = 2'sd0;
      end else begin
         detent_steps = 2'sd0;
         residual_in  = delta[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= PH_00;
         residual_ff   <= 2'sd0;
      end else if (advance) begin
         last_phase_ff <= phase;
         residual_ff   <= residual_in;
      end
   end

endmodule

FILE: hdl/ebq_buttons.sv
// Millisecond counter and per-button debounce with short/long press classification.
module ebq_buttons #(
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          ms_tick,
   input  logic [ebq_pkg::NUM_BUTTONS-1:0] button_levels,
   input  ebq_pkg::cfg_type              cfg,
   output ebq_pkg::event_type            events [ebq_pkg::NUM_BUTTONS]
);
   import ebq_pkg::*;

   logic [TIME_BITS-1:0] time_ff;
   logic [TIME_BITS-1:0] time_in;
   logic [TIME_BITS-1:0] stamp_ff [NUM_BUTTONS];
   logic [TIME_BITS-1:0] stamp_in [NUM_BUTTONS];
   logic [TIME_BITS-1:0] held     [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] pressed_ff;
   logic [NUM_BUTTONS-1:0] pressed_in;

   // the tick lands before this sample is judged
   assign time_in = ms_tick ? time_ff + TIME_BITS'(1) : time_ff;

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         held[i]       = time_in - stamp_ff[i];
         stamp_in[i]   = stamp_ff[i];
         pressed_in[i] = pressed_ff[i];
         events[i]     = EVT_NONE;
         if (!pressed_ff[i] && !button_levels[i]) begin
            if (held[i] >= TIME_BITS'(cfg.debounce_ms)) begin
               stamp_in[i]   = time_in;
               pressed_in[i] = 1'b1;
            end
         end else if (pressed_ff[i] && button_levels[i]) begin
            if (held[i] >= TIME_BITS'(cfg.debounce_ms)) begin
               pressed_in[i] = 1'b0;
               events[i] = (held[i] < TIME_BITS'(cfg.long_press_ms)) ? EVT_SHORT : EVT_LONG;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         pressed_ff <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            stamp_ff[i] <= '0;
         end
      end else if (advance) begin
         time_ff    <= time_in;
         pressed_ff <= pressed_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            stamp_ff[i] <= stamp_in[i];
         end
      end
   end

endmodule

FILE: hdl/encoder_and_button_qualifier_core.sv
// Top level: encoder and button qualifier with input register, result register and CSRs.
//
//   channel    direction  payload                                   beat
//   req_chan   in         phase_a, phase_b, button_levels, ms_tick  one pin sample
//   rsp_chan   out        detent_steps, five button events          one result per sample
//   csr_chan   in         addr, wdata                               one register write
//
// One sample per clock while rsp_chan is ready; path: input register, then result register.
// The decode and debounce logic sits between those two registers and updates state
// when a sample moves into the result register.
// Sync active-high reset covers all but in_ff/out_ff; debounce 50 ms, long press 1000 ms.
// A stalled result holds while the input register keeps accepting until it is full.
module encoder_and_button_qualifier_core #(
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   ebq_chan_if.sink     req_chan,
   ebq_chan_if.source   rsp_chan,
   ebq_chan_if.sink     csr_chan
);
   import ebq_pkg::*;

   req_type   in_ff;
   logic      in_valid_ff;
   rsp_type   out_ff;
   rsp_type   out_in;
   logic      out_valid_ff;
   cfg_type   cfg_ff;
   logic      advance;
   logic signed [1:0] detent_steps;
   event_type events [NUM_BUTTONS];

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   ebq_quad u_quad (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .phase        ({in_ff.phase_a, in_ff.phase_b}),
      .detent_steps (detent_steps)
   );

   ebq_buttons #(
      .TIME_BITS (TIME_BITS)
   ) u_buttons (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .ms_tick       (in_ff.ms_tick),
      .button_levels (in_ff.button_levels),
      .cfg           (cfg_ff),
      .events        (events)
   );

   always_comb begin
      out_in.detent_steps  = detent_steps;
      out_in.knob_event    = events[BTN_KNOB];
      out_in.volt_event    = events[BTN_VOLT];
      out_in.time_event    = events[BTN_TIME];
      out_in.trigger_event = events[BTN_TRIGGER];
      out_in.ok_event      = events[BTN_OK];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff <= req_chan.data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.data.addr)
            CSR_DEBOUNCE:   cfg_ff.debounce_ms   <= csr_chan.data.wdata;
            CSR_LONG_PRESS: cfg_ff.long_press_ms <= csr_chan.data.wdata;
            default: ;
         endcase
      end
   end

   // a sample that leaves the input register always lands in the result register
   assert property (@(posedge clock) disable iff (reset) advance |=> out_valid_ff)
      else $error("advanced sample did not reach the result register");

   // a full input register with a stalled result must refuse new beats
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input register overrun");

   // residual bookkeeping keeps steps within one detent
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.detent_steps != -2'sd2))
      else $error("detent step out of range");

   // a stalled result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> $stable(out_ff))
      else $error("stalled result changed");

endmodule

FILE: tb/tb_top.sv
// Testbench for the encoder and button qualifier: directed and random pin samples, scoreboard.
module tb_top;
   import ebq_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;

   class detent_scoreboard;
      logic [CSR_DATA_BITS-1:0] debounce;
      logic [CSR_DATA_BITS-1:0] long_press;
      logic [1:0]               last_phase;
      logic [31:0]              quad_count;
      logic [31:0]              reported_count;
      logic [31:0]              time_now;
      logic [31:0]              press_stamp [NUM_BUTTONS];
      bit                       is_pressed [NUM_BUTTONS];
      rsp_type                  expected_q [$];
      int                       errors;
      int                       checked;
      int                       presses;
      int                       short_releases;
      int                       long_releases;

      function new();
         debounce       = DEBOUNCE_RESET;
         long_press     = LONG_PRESS_RESET;
         last_phase     = PH_00;
         quad_count     = '0;
         reported_count = '0;
         time_now       = '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_stamp[i] = '0;
            is_pressed[i]  = 1'b0;
         end
      endfunction

      // position of a phase along the clockwise cycle 00 -> 01 -> 11 -> 10
      static function int unsigned quad_pos(logic [1:0] ph);
         case (ph)
            PH_00:   return 0;
            PH_01:   return 1;
            PH_11:   return 2;
            default: return 3;
         endcase
      endfunction

      function void set_reg(logic [CSR_ADDR_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_DEBOUNCE:   debounce = val;
            CSR_LONG_PRESS: long_press = val;
            default: ;
         endcase
      endfunction

      function void note_sample(req_type s);
         logic [1:0]  ph;
         int unsigned delta;
         logic [31:0] diff;
         longint      d;
         longint      rem;
         logic [31:0] held;
         bit          low;
         event_type   ev [NUM_BUTTONS];
         rsp_type     r;
         ph = {s.phase_a, s.phase_b};
         delta = (quad_pos(ph) - quad_pos(last_phase)) & 3;
         // a distance of two is a double jump and moves nothing
         if (delta == 1)
            quad_count = quad_count + 32'd1;
         else if (delta == 3)
            quad_count = quad_count - 32'd1;
         last_phase = ph;

         diff = quad_count - reported_count;
         d = longint'(signed'(diff));
         rem = d % 2;
         r.detent_steps = 2'(d / 2);
         reported_count = quad_count - 32'(rem);

         if (s.ms_tick)
            time_now = time_now + 32'd1;

         for (int i = 0; i < NUM_BUTTONS; i++) begin
            low = (s.button_levels[i] == 1'b0);
            ev[i] = EVT_NONE;
            held = time_now - press_stamp[i];
            if (!is_pressed[i] && low) begin
               if (held >= {16'd0, debounce}) begin
                  press_stamp[i] = time_now;
                  is_pressed[i] = 1'b1;
                  presses++;
               end
            end else if (is_pressed[i] && !low) begin
               if (held >= {16'd0, debounce}) begin
                  is_pressed[i] = 1'b0;
                  if (held < {16'd0, long_press}) begin
                     ev[i] = EVT_SHORT;
                     short_releases++;
                  end else begin
                     ev[i] = EVT_LONG;
                     long_releases++;
                  end
               end
            end
         end
         r.knob_event    = ev[BTN_KNOB];
         r.volt_event    = ev[BTN_VOLT];
         r.time_event    = ev[BTN_TIME];
         r.trigger_event = ev[BTN_TRIGGER];
         r.ok_event      = ev[BTN_OK];
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [1:0] exp_val, logic [1:0] act_val);
         if (act_val !== exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
         end
      endfunction

      function void check_result(rsp_type act);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing pending, expected none, actual %h",
                     $time, act);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare_field("detent_steps", e.detent_steps, act.detent_steps);
         compare_field("knob_event", e.knob_event, act.knob_event);
         compare_field("volt_event", e.volt_event, act.volt_event);
         compare_field("time_event", e.time_event, act.time_event);
         compare_field("trigger_event", e.trigger_event, act.trigger_event);
         compare_field("ok_event", e.ok_event, act.ok_event);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_en = 1'b1;
   int   idle_cycles = 0;
   int   sent = 0;
   int   settings = 1;

   logic [1:0] enc_phase = PH_00;
   int         enc_dir = 1;
   logic [4:0] btn_levels = 5'h1F;

   detent_scoreboard sb = new();

   ebq_chan_if #(.payload_type(req_type)) req_if();
   ebq_chan_if #(.payload_type(rsp_type)) rsp_if();
   ebq_chan_if #(.payload_type(csr_type)) csr_if();

   encoder_and_button_qualifier_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            sb.set_reg(csr_if.data.addr, csr_if.data.wdata);
         if (req_if.valid && req_if.ready)
            sb.note_sample(req_if.data);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.data);
         if ((csr_if.valid && csr_if.ready) || (req_if.valid && req_if.ready) ||
             (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result side: random stall before each beat
   initial begin
      int unsigned stall;
      rsp_if.ready = 1'b0;
      forever begin
         stall = idle_en ? $urandom_range(0, 4) : 0;
         repeat (stall) @(negedge clock) rsp_if.ready <= 1'b0;
         @(negedge clock) rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_if.valid && rsp_if.ready)) @(posedge clock);
      end
   end

   function automatic logic [1:0] gray_of(int pos);
      case (pos & 3)
         0:       return PH_00;
         1:       return PH_01;
         2:       return PH_11;
         default: return PH_10;
      endcase
   endfunction

   task automatic send_sample(input logic a, input logic b, input logic [4:0] lv,
                              input logic t);
      int unsigned gap;
      req_type     s;
      s.phase_a = a;
      s.phase_b = b;
      s.button_levels = lv;
      s.ms_tick = t;
      gap = idle_en ? $urandom_range(0, 4) : 0;
      repeat (gap) @(negedge clock) req_if.valid <= 1'b0;
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data <= s;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
      sent++;
   endtask

   // stop sending and wait for every pending result
   task automatic drain();
      @(negedge clock) req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_type w;
      w.addr = idx;
      w.wdata = val;
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= w;
      @(posedge clock);
      while (!(csr_if.valid && csr_if.ready)) @(posedge clock);
      @(negedge clock) csr_if.valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] deb,
                            input logic [CSR_DATA_BITS-1:0] lp);
      drain();
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_LONG_PRESS, lp);
      settings++;
   endtask

   // mostly legal encoder walks and held buttons, with some jumps and bounce
   task automatic run_random(input int count, input int tick_pct);
      int r;
      for (int k = 0; k < count; k++) begin
         if (k % 100 == 0)
            idle_en = ($urandom_range(0, 3) != 0);
         if (k == count / 2)
            drain();
         r = $urandom_range(0, 99);
         if (r < 8) begin
            enc_phase = 2'($urandom);
         end else if (r >= 20) begin
            if ($urandom_range(0, 9) == 0)
               enc_dir = -enc_dir;
            enc_phase = gray_of(int'(detent_scoreboard::quad_pos(enc_phase)) + enc_dir);
         end
         r = $urandom_range(0, 99);
         if (r < 15)
            btn_levels[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
         else if (r < 18)
            btn_levels = 5'($urandom);
         send_sample(enc_phase[1], enc_phase[0], btn_levels,
                     $urandom_range(0, 99) < tick_pct);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // clockwise walk, then counterclockwise, at reset settings
      send_sample(1'b0, 1'b1, 5'h1F, 1'b1);
      send_sample(1'b1, 1'b1, 5'h1F, 1'b0);
      send_sample(1'b1, 1'b0, 5'h15, 1'b1);
      send_sample(1'b0, 1'b0, 5'h0A, 1'b1);
      send_sample(1'b1, 1'b0, 5'h1F, 1'b0);
      send_sample(1'b1, 1'b1, 5'h1F, 1'b1);
      send_sample(1'b0, 1'b1, 5'h1F, 1'b1);
      send_sample(1'b0, 1'b0, 5'h1F, 1'b0);
      // double jumps and a repeated phase; presses this soon after reset are ignored
      send_sample(1'b1, 1'b1, 5'h00, 1'b1);
      send_sample(1'b0, 1'b0, 5'h00, 1'b1);
      send_sample(1'b0, 1'b1, 5'h00, 1'b1);
      send_sample(1'b1, 1'b0, 5'h00, 1'b1);
      send_sample(1'b1, 1'b0, 5'h00, 1'b0);
      send_sample(1'b0, 1'b1, 5'h1F, 1'b1);

      configure(16'd2, 16'd5);
      send_sample(1'b0, 1'b1, 5'b01110, 1'b0);
      send_sample(1'b0, 1'b1, 5'h1F, 1'b1);      // release too soon, stays pressed
      send_sample(1'b0, 1'b1, 5'b01110, 1'b1);
      send_sample(1'b0, 1'b1, 5'h1F, 1'b0);      // short
      send_sample(1'b0, 1'b1, 5'h00, 1'b1);
      send_sample(1'b0, 1'b1, 5'h00, 1'b1);
      send_sample(1'b0, 1'b1, 5'h00, 1'b1);
      send_sample(1'b0, 1'b1, 5'h00, 1'b1);
      send_sample(1'b0, 1'b1, 5'h00, 1'b1);
      send_sample(1'b0, 1'b1, 5'h1F, 1'b1);      // long
      enc_phase = PH_01;

      configure(16'd0, 16'd0);
      run_random(350, 50);
      configure(16'd3, 16'd12);
      run_random(400, 60);
      // writes to unused indexes must leave the settings alone
      drain();
      write_reg(8'd2, 16'hFFFF);
      write_reg(8'hFF, 16'h0000);
      run_random(200, 50);
      configure(16'hFFFF, 16'hFFFF);
      run_random(100, 100);
      configure(16'd1, 16'hFFFF);
      run_random(200, 70);
      configure(16'($urandom_range(0, 6)), 16'($urandom_range(4, 40)));
      run_random(350, 50);
      configure(16'd2, 16'd1);
      run_random(300, 80);

      drain();
      if (sb.expected_q.size() != 0)
         $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      $display("Ran %0d pin samples over %0d register settings; %0d results checked.",
               sent, settings, sb.checked);
      $display("Qualified %0d presses, %0d short and %0d long releases; %0d mismatches.",
               sb.presses, sb.short_releases, sb.long_releases, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/ebq_pkg.sv
hdl/ebq_chan_if.sv
hdl/ebq_quad.sv
hdl/ebq_buttons.sv
hdl/encoder_and_button_qualifier_core.sv
tb/tb_top.sv
